### rtl/kes_pkg.sv
// ----------------------------------------------------------------------------
// kes_pkg
// Shared constants, widths and types for the exhaustive-search knapsack block.
// ----------------------------------------------------------------------------
package kes_pkg;

  // sizing
  localparam int MAX_ITEMS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int VALUE_BITS  = 16;

  // fixed field widths
  localparam int IN_W     = 16;
  localparam int CAP_W    = 20;
  localparam int PROFIT_W = 20;
  localparam int SEL_W    = 16;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // derived widths
  localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SUBSET_W = MAX_ITEMS + 1;
  localparam int WSUM_W   = WEIGHT_BITS + CNT_W;
  localparam int VSUM_W   = VALUE_BITS + CNT_W;
  localparam int WCMP_W   = (WSUM_W > CAP_W) ? WSUM_W : CAP_W;
  localparam int PCMP_W   = (VSUM_W > PROFIT_W) ? VSUM_W : PROFIT_W;

  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

  // register index (word address bit)
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ACC,
    ST_EVAL,
    ST_DONE
  } kes_state_e;

endpackage

### rtl/kes_apb_regs.sv
// ----------------------------------------------------------------------------
// kes_apb_regs
// APB register file: holds the capacity register.
// ----------------------------------------------------------------------------
module kes_apb_regs import kes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [CAP_W-1:0]  capacity_o
);

  logic [CAP_W-1:0] capacity_q;
  logic             wr_beat;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite && pready;

  // word decode only; byte offset bits are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
    end else if (wr_beat && (paddr[2] == REG_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = DATA_W'(capacity_q);
    end else begin
      prdata = '0;
    end
  end

  assign capacity_o = capacity_q;

endmodule

### rtl/knapsack_exhaustive_search_top.sv
// ----------------------------------------------------------------------------
// knapsack_exhaustive_search_top
// 0/1 knapsack by brute force: loads items, then walks every subset with one
// shared accumulator and keeps the first best subset within capacity.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  items in  | start_i / busy_o       | item_weight_i, item_value_i, last_item_i
//  result    | done_o (1-cycle strobe)| best_profit_o, best_selection_o, overflow_o
//  config    | APB psel/penable/pwrite| paddr, pwdata, prdata, pready
//
//  Items load at one a cycle while busy_o is low.
//  After the last item busy_o rises; each subset then takes one setup step,
//  one accumulate step per stored item and one compare step, and done_o
//  follows the last compare, after which busy_o falls.
//  The single adder/compare pair keeps the walk serial.
//  Reset clears the batch, the best-so-far state and capacity; the result
//  strobe cannot be stalled.
// ----------------------------------------------------------------------------
module knapsack_exhaustive_search_top import kes_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [IN_W-1:0]     item_weight_i,
  input  logic [IN_W-1:0]     item_value_i,
  input  logic                last_item_i,
  output logic                done_o,
  output logic [PROFIT_W-1:0] best_profit_o,
  output logic [SEL_W-1:0]    best_selection_o,
  output logic                overflow_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [CAP_W-1:0] capacity;

  kes_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  kes_state_e state_q, state_d;

  logic [WEIGHT_BITS-1:0] weight_mem_q [MAX_ITEMS];
  logic [VALUE_BITS-1:0]  value_mem_q  [MAX_ITEMS];

  logic [CNT_W-1:0]     count_q;
  logic                 ovf_q;
  logic [SUBSET_W-1:0]  subset_q;
  logic [SUBSET_W-1:0]  subset_nxt;
  logic [MAX_ITEMS-1:0] shreg_q;
  logic [IDX_W-1:0]     idx_q;
  logic [WSUM_W-1:0]    wsum_q;
  logic [VSUM_W-1:0]    vsum_q;
  logic [MAX_ITEMS-1:0] sel_q;
  logic [VSUM_W-1:0]    best_q;
  logic [MAX_ITEMS-1:0] best_mask_q;

  logic accept;
  logic store_ok;
  logic last_subset;
  logic fits;
  logic better;
  logic [WCMP_W-1:0] wsum_cmp;
  logic [WCMP_W-1:0] cap_cmp;
  logic [PCMP_W-1:0] best_ext;

  assign accept      = start_i && !busy_o;
  assign store_ok    = (count_q < CNT_W'(MAX_ITEMS));
  assign subset_nxt  = subset_q + SUBSET_W'(1);
  assign last_subset = subset_nxt[count_q];
  assign wsum_cmp    = WCMP_W'(wsum_q);
  assign cap_cmp     = WCMP_W'(capacity);
  assign fits        = (wsum_cmp <= cap_cmp);
  assign better      = (vsum_q > best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_item_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = (count_q == '0) ? ST_EVAL : ST_ACC;
      end
      ST_ACC: begin
        if (idx_q == '0) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = last_subset ? ST_DONE : ST_SETUP;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // item store (no reset, read only below count_q)
  always_ff @(posedge clk_i) begin
    if (accept && store_ok) begin
      weight_mem_q[count_q[IDX_W-1:0]] <= WEIGHT_BITS'(item_weight_i);
      value_mem_q[count_q[IDX_W-1:0]]  <= VALUE_BITS'(item_value_i);
    end
  end

  // batch and best-so-far state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      subset_q    <= '0;
      best_q      <= '0;
      best_mask_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (store_ok) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            subset_q    <= '0;
            best_q      <= '0;
            best_mask_q <= '0;
          end
        end
        ST_EVAL: begin
          if (fits && better) begin
            best_q      <= vsum_q;
            best_mask_q <= sel_q;
          end
          if (!last_subset) subset_q <= subset_nxt;
        end
        ST_DONE: begin
          count_q     <= '0;
          ovf_q       <= 1'b0;
          subset_q    <= '0;
          best_q      <= '0;
          best_mask_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // shared accumulator: counter bit 0 is the last item, so walk items downwards
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SETUP: begin
        shreg_q <= subset_q[MAX_ITEMS-1:0];
        idx_q   <= IDX_W'(count_q - CNT_W'(1));
        wsum_q  <= '0;
        vsum_q  <= '0;
        sel_q   <= '0;
      end
      ST_ACC: begin
        if (shreg_q[0]) begin
          wsum_q <= wsum_q + WSUM_W'(weight_mem_q[idx_q]);
          vsum_q <= vsum_q + VSUM_W'(value_mem_q[idx_q]);
          sel_q  <= sel_q | (MAX_ITEMS'(1) << idx_q);
        end
        shreg_q <= shreg_q >> 1;
        idx_q   <= idx_q - IDX_W'(1);
      end
      default: ;
    endcase
  end

  assign best_ext = PCMP_W'(best_q);

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = (state_q == ST_DONE);
  assign best_profit_o    = (best_ext > PCMP_W'(PROFIT_MAX)) ? PROFIT_MAX
                                                             : PROFIT_W'(best_q);
  assign best_selection_o = SEL_W'(best_mask_q);
  assign overflow_o       = ovf_q;

endmodule

### rtl/kes_checker.sv
// ----------------------------------------------------------------------------
// kes_checker
// Port-level checks on the knapsack search block, bound to the top level.
// ----------------------------------------------------------------------------
module kes_checker import kes_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                last_item_i,
  input logic                done_o,
  input logic [PROFIT_W-1:0] best_profit_o,
  input logic [SEL_W-1:0]    best_selection_o
);

  // a result only comes out of a running search
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result beat while idle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block still busy after result beat");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_item_i) |=> (!busy_o && !done_o))
    else $error("non-final item left the block busy");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_item_i) |=> (busy_o && !done_o))
    else $error("final item did not start the search");

  // nothing beats zero profit, so the empty subset is reported
  a_zero_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (best_profit_o == '0)) |-> (best_selection_o == '0))
    else $error("zero profit with a non-empty selection");

endmodule

bind knapsack_exhaustive_search_top kes_checker u_kes_checker (.*);
